### src/psrb_pkg.sv
// ----------------------------------------------------------------------------
// psrb_pkg
// Shared sizes, result codes, command and status types for the per-stream
// reorder buffer.
// ----------------------------------------------------------------------------
package psrb_pkg;

  // Sizing of the buffer.
  localparam int NUM_STREAMS = 16;
  localparam int WINDOW      = 16;
  localparam int TAG_BITS    = 16;

  localparam int STREAM_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int PTR_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = PTR_W + 1;
  localparam int SLOTS    = NUM_STREAMS * WINDOW;
  localparam int SLOT_W   = $clog2(SLOTS);

  // Depth of the command queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Result kinds.
  localparam logic [2:0] KIND_RELEASED = 3'd0;
  localparam logic [2:0] KIND_HELD     = 3'd1;
  localparam logic [2:0] KIND_STALE    = 3'd2;
  localparam logic [2:0] KIND_DUP      = 3'd3;
  localparam logic [2:0] KIND_BEYOND   = 3'd4;

  // Operation chosen by the front for one request.
  typedef enum logic [1:0] {
    OP_RELEASE = 2'd0,
    OP_HOLD    = 2'd1,
    OP_STALE   = 2'd2,
    OP_BEYOND  = 2'd3
  } op_t;

  // Classified request handed from front to back.
  typedef struct packed {
    op_t                 op;
    logic [3:0]          stream;
    logic [STREAM_W-1:0] idx;
    logic [31:0]         seq;
    logic [TAG_BITS-1:0] tag;
    logic [PTR_W-1:0]    offset;
  } cmd_t;

  // Status of the front.
  typedef struct packed {
    logic [NUM_STREAMS-1:0] pend;
  } front_stat_t;

  // Status of the back, including the end of a release burst.
  typedef struct packed {
    logic                idle;
    logic                done_valid;
    logic [STREAM_W-1:0] done_idx;
  } back_stat_t;

  // Ring position reduced modulo the window; the sum stays below twice it.
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] res;
    begin
      res = sum;
      if (sum >= SUM_W'(WINDOW)) begin
        res = sum - SUM_W'(WINDOW);
      end
      return PTR_W'(res);
    end
  endfunction

  // Flat slot index of a stream's ring position.
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [STREAM_W-1:0] idx,
                                                  input logic [PTR_W-1:0] ptr);
    begin
      return SLOT_W'(32'(idx) * WINDOW + 32'(ptr));
    end
  endfunction

endpackage

### src/psrb_queue.sv
// ----------------------------------------------------------------------------
// psrb_queue
// Short command queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module psrb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psrb_pkg::cmd_t  push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output psrb_pkg::cmd_t  head_cmd
);

  psrb_pkg::cmd_t                  entries [psrb_pkg::QDEPTH];
  logic [psrb_pkg::QPTR_W-1:0]     wr_ptr;
  logic [psrb_pkg::QPTR_W-1:0]     rd_ptr;
  logic [psrb_pkg::QCNT_W-1:0]     count;

  assign valid    = (count != '0);
  assign ready    = (count != psrb_pkg::QCNT_W'(psrb_pkg::QDEPTH));
  assign head_cmd = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == psrb_pkg::QPTR_W'(psrb_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == psrb_pkg::QPTR_W'(psrb_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/psrb_front.sv
// ----------------------------------------------------------------------------
// psrb_front
// Accepts frame requests, measures the distance to the stream's expected
// sequence and queues a classified command. A stream with a release still
// in flight is held back until the back has advanced its expected sequence.
// ----------------------------------------------------------------------------
module psrb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     stream_num,
  input  logic [31:0]                    seq_num,
  input  logic [15:0]                    frame_tag,
  output logic [psrb_pkg::STREAM_W-1:0]  lookup_idx,
  input  logic [31:0]                    expected,
  output logic                           q_push,
  output psrb_pkg::cmd_t                 q_cmd,
  input  logic                           q_ready,
  input  psrb_pkg::back_stat_t           back_stat,
  output psrb_pkg::front_stat_t          stat
);

  logic                              fr_valid;
  logic [3:0]                        fr_stream;
  logic [31:0]                       fr_seq;
  logic [psrb_pkg::TAG_BITS-1:0]     fr_tag;
  logic [psrb_pkg::NUM_STREAMS-1:0]  pend;
  logic [psrb_pkg::NUM_STREAMS-1:0]  pend_next;

  logic [psrb_pkg::STREAM_W-1:0]     fr_idx;
  logic                              in_range;
  logic                              blocked;
  logic                              go;
  logic [31:0]                       distance;
  psrb_pkg::op_t                     op;

  // Classification of the staged request.
  always_comb begin
    fr_idx   = psrb_pkg::STREAM_W'(fr_stream);
    in_range = (32'(fr_stream) < psrb_pkg::NUM_STREAMS);
    distance = fr_seq - expected;
    if (distance[31]) begin
      op = psrb_pkg::OP_STALE;
    end else if (distance >= 32'(psrb_pkg::WINDOW)) begin
      op = psrb_pkg::OP_BEYOND;
    end else if (distance != '0) begin
      op = psrb_pkg::OP_HOLD;
    end else begin
      op = psrb_pkg::OP_RELEASE;
    end
    blocked = pend[fr_idx];
    q_push  = fr_valid && in_range && !blocked && q_ready;
    // An unknown stream is retired without any result.
    go      = fr_valid && (!in_range || (!blocked && q_ready));
  end

  assign lookup_idx = fr_idx;
  assign in_ready   = !fr_valid || go;
  assign stat.pend  = pend;

  always_comb begin
    q_cmd.op     = op;
    q_cmd.stream = fr_stream;
    q_cmd.idx    = fr_idx;
    q_cmd.seq    = fr_seq;
    q_cmd.tag    = fr_tag;
    q_cmd.offset = psrb_pkg::PTR_W'(distance);
  end

  // Release-in-flight marks, one per stream.
  always_comb begin
    pend_next = pend;
    if (back_stat.done_valid) begin
      pend_next[back_stat.done_idx] = 1'b0;
    end
    if (q_push && (op == psrb_pkg::OP_RELEASE)) begin
      pend_next[fr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
      pend     <= '0;
    end else begin
      pend <= pend_next;
      if (in_valid && in_ready) begin
        fr_valid <= 1'b1;
      end else if (go) begin
        fr_valid <= 1'b0;
      end
    end
  end

  // Staging register for the accepted request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_stream <= stream_num;
      fr_seq    <= seq_num;
      fr_tag    <= psrb_pkg::TAG_BITS'(frame_tag);
    end
  end

endmodule

### src/psrb_back.sv
// ----------------------------------------------------------------------------
// psrb_back
// Carries out queued commands: holds early frames in the slot store, reports
// drops, and on an in-order frame walks the following held slots, one per
// cycle whenever the output register can take a result, into that register.
// ----------------------------------------------------------------------------
module psrb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [psrb_pkg::STREAM_W-1:0]  lookup_idx,
  output logic [31:0]                    expected,
  input  logic                           q_valid,
  input  psrb_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     kind,
  output logic [3:0]                     out_stream,
  output logic [31:0]                    out_seq,
  output logic [15:0]                    out_tag,
  output logic                           last,
  output psrb_pkg::back_stat_t           stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Per-stream state and slot store.
  logic [31:0]                    expected_seq [psrb_pkg::NUM_STREAMS];
  logic [psrb_pkg::PTR_W-1:0]     ring_head    [psrb_pkg::NUM_STREAMS];
  logic [psrb_pkg::SLOTS-1:0]     slot_valid;
  logic [psrb_pkg::TAG_BITS-1:0]  tag_mem      [psrb_pkg::SLOTS];
  logic [psrb_pkg::TAG_BITS-1:0]  rd_data;

  // Context of the release burst being walked.
  logic [3:0]                     cur_stream;
  logic [psrb_pkg::STREAM_W-1:0]  cur_idx;
  logic [31:0]                    cur_seq;
  logic [psrb_pkg::PTR_W-1:0]     cur_head;
  logic [psrb_pkg::CNT_W-1:0]     cnt;
  logic [psrb_pkg::CNT_W-1:0]     cnt_next;
  logic [psrb_pkg::CNT_W-1:0]     cnt_inc;

  logic [psrb_pkg::PTR_W-1:0]     hd;
  logic [psrb_pkg::PTR_W-1:0]     hold_ptr;
  logic [psrb_pkg::SLOT_W-1:0]    hold_addr;
  logic [psrb_pkg::PTR_W-1:0]     rel_ptr;
  logic [psrb_pkg::SLOT_W-1:0]    rel_addr;
  logic [psrb_pkg::PTR_W-1:0]     walk_ptr;
  logic [psrb_pkg::SLOT_W-1:0]    walk_addr;
  logic [psrb_pkg::PTR_W-1:0]     nxt_ptr;
  logic [psrb_pkg::SLOT_W-1:0]    nxt_addr;

  logic                           out_free;
  logic                           emit;
  logic [2:0]                     e_kind;
  logic [3:0]                     e_stream;
  logic [31:0]                    e_seq;
  logic [psrb_pkg::TAG_BITS-1:0]  e_tag;
  logic                           e_last;
  logic                           set_valid;
  logic                           clr_valid;
  logic                           rd_en;
  logic [psrb_pkg::SLOT_W-1:0]    rd_addr;
  logic                           load_cur;
  logic                           upd;
  logic [psrb_pkg::STREAM_W-1:0]  upd_idx;
  logic [31:0]                    upd_seq;
  logic [psrb_pkg::PTR_W-1:0]     upd_head;

  assign expected = expected_seq[lookup_idx];

  // Slot positions for the queued command and for the running burst.
  always_comb begin
    hd        = ring_head[q_cmd.idx];
    hold_ptr  = psrb_pkg::wrap_ptr(psrb_pkg::SUM_W'(hd) + psrb_pkg::SUM_W'(q_cmd.offset));
    hold_addr = psrb_pkg::slot_addr(q_cmd.idx, hold_ptr);
    rel_ptr   = psrb_pkg::wrap_ptr(psrb_pkg::SUM_W'(hd) + psrb_pkg::SUM_W'(1));
    rel_addr  = psrb_pkg::slot_addr(q_cmd.idx, rel_ptr);
    cnt_inc   = cnt + 1'b1;
    walk_ptr  = psrb_pkg::wrap_ptr(psrb_pkg::SUM_W'(cur_head) + psrb_pkg::SUM_W'(cnt));
    walk_addr = psrb_pkg::slot_addr(cur_idx, walk_ptr);
    nxt_ptr   = psrb_pkg::wrap_ptr(psrb_pkg::SUM_W'(cur_head) + psrb_pkg::SUM_W'(cnt_inc));
    nxt_addr  = psrb_pkg::slot_addr(cur_idx, nxt_ptr);
  end

  // Command execution and release walk.
  always_comb begin
    out_free   = !out_valid || out_ready;
    state_next = state;
    cnt_next   = cnt;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_kind     = psrb_pkg::KIND_RELEASED;
    e_stream   = q_cmd.stream;
    e_seq      = q_cmd.seq;
    e_tag      = q_cmd.tag;
    e_last     = 1'b1;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rel_addr;
    load_cur   = 1'b0;
    upd        = 1'b0;
    upd_idx    = q_cmd.idx;
    upd_seq    = q_cmd.seq + 32'd1;
    upd_head   = rel_ptr;
    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_cmd.op)
            psrb_pkg::OP_STALE: begin
              e_kind = psrb_pkg::KIND_STALE;
            end
            psrb_pkg::OP_BEYOND: begin
              e_kind = psrb_pkg::KIND_BEYOND;
            end
            psrb_pkg::OP_HOLD: begin
              if (slot_valid[hold_addr]) begin
                e_kind = psrb_pkg::KIND_DUP;
              end else begin
                e_kind    = psrb_pkg::KIND_HELD;
                set_valid = 1'b1;
              end
            end
            psrb_pkg::OP_RELEASE: begin
              e_kind = psrb_pkg::KIND_RELEASED;
              if (slot_valid[rel_addr]) begin
                // A held frame follows: start the walk.
                e_last     = 1'b0;
                rd_en      = 1'b1;
                load_cur   = 1'b1;
                cnt_next   = psrb_pkg::CNT_W'(1);
                state_next = S_WALK;
              end else begin
                upd = 1'b1;
              end
            end
            default: begin
              e_kind = psrb_pkg::KIND_STALE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = psrb_pkg::KIND_RELEASED;
          e_stream  = cur_stream;
          e_seq     = cur_seq + 32'(cnt);
          e_tag     = rd_data;
          clr_valid = 1'b1;
          if ((cnt_inc < psrb_pkg::CNT_W'(psrb_pkg::WINDOW)) && slot_valid[nxt_addr]) begin
            e_last   = 1'b0;
            rd_en    = 1'b1;
            rd_addr  = nxt_addr;
            cnt_next = cnt_inc;
          end else begin
            upd        = 1'b1;
            upd_idx    = cur_idx;
            upd_seq    = cur_seq + 32'(cnt_inc);
            upd_head   = nxt_ptr;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign stat.idle       = (state == S_IDLE);
  assign stat.done_valid = upd;
  assign stat.done_idx   = upd_idx;

  // Control state, per-stream state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
      for (int i = 0; i < psrb_pkg::NUM_STREAMS; i++) begin
        expected_seq[i] <= '0;
        ring_head[i]    <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (set_valid) begin
        slot_valid[hold_addr] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[walk_addr] <= 1'b0;
      end
      if (upd) begin
        expected_seq[upd_idx] <= upd_seq;
        ring_head[upd_idx]    <= upd_head;
      end
    end
  end

  // Burst context and output payload.
  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (load_cur) begin
      cur_stream <= q_cmd.stream;
      cur_idx    <= q_cmd.idx;
      cur_seq    <= q_cmd.seq;
      cur_head   <= hd;
    end
    if (emit) begin
      kind       <= e_kind;
      out_stream <= e_stream;
      out_seq    <= e_seq;
      out_tag    <= 16'(e_tag);
      last       <= e_last;
    end
  end

  // Tag store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (set_valid) begin
      tag_mem[hold_addr] <= q_cmd.tag;
    end
    if (rd_en) begin
      rd_data <= tag_mem[rd_addr];
    end
  end

endmodule

### src/per_stream_reorder_buffer.sv
// The first result of a request passes the front's staging register, the command
// queue and the output register. Hold and drop requests give one result each; a
// release gives one result per cycle unless stalled, via the single-port tag store.
// A request for a stream whose release burst is still running waits until it ends.
// Reset clears expected sequences, ring heads and slot valid bits at once; the
// tag store is not cleared, so the block accepts requests right after reset.
// ----------------------------------------------------------------------------
// per_stream_reorder_buffer
// Top level: classifying front, command queue and executing back.
// ----------------------------------------------------------------------------
module per_stream_reorder_buffer (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [3:0]   stream_num,
  input  logic [31:0]  seq_num,
  input  logic [15:0]  frame_tag,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   kind,
  output logic [3:0]   out_stream,
  output logic [31:0]  out_seq,
  output logic [15:0]  out_tag,
  output logic         last
);

  logic [psrb_pkg::STREAM_W-1:0]  lookup_idx;
  logic [31:0]                    expected;
  logic                           q_push;
  logic                           q_ready;
  logic                           q_pop;
  logic                           q_valid;
  psrb_pkg::cmd_t                 push_cmd;
  psrb_pkg::cmd_t                 head_cmd;
  psrb_pkg::front_stat_t          front_stat;
  psrb_pkg::back_stat_t           back_stat;

  // Front: accept and classify.
  psrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .stream_num (stream_num),
    .seq_num    (seq_num),
    .frame_tag  (frame_tag),
    .lookup_idx (lookup_idx),
    .expected   (expected),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_ready    (q_ready),
    .back_stat  (back_stat),
    .stat       (front_stat)
  );

  // Command queue.
  psrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  // Back: execute and deliver results.
  psrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .lookup_idx (lookup_idx),
    .expected   (expected),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_stream (out_stream),
    .out_seq    (out_seq),
    .out_tag    (out_tag),
    .last       (last),
    .stat       (back_stat)
  );

`ifndef SYNTHESIS
  // A finished release always belongs to a stream the front marked busy.
  a_done_was_pending: assert property (@(posedge clk) disable iff (rst)
    back_stat.done_valid |-> front_stat.pend[back_stat.done_idx])
    else $error("release finished on a stream without a pending mark");

  // With nothing queued and the back idle, no release can be in flight.
  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    (!q_valid && back_stat.idle) |-> (front_stat.pend == '0))
    else $error("pending release mark left behind");

  // Only releases produce multi-result bursts.
  a_single_unless_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != psrb_pkg::KIND_RELEASED)) |-> last)
    else $error("non-release result not marked last");

  // Within a burst, the next release follows at once with the next sequence.
  a_burst_consecutive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && (kind == psrb_pkg::KIND_RELEASED) &&
       (out_seq == $past(out_seq) + 32'd1)))
    else $error("release burst broken or out of sequence");
`endif

endmodule
